>>> hdl/dabm_pkg.sv
// ----------------------------------------------------------------------------
// dabm_pkg
// Shared types and codes of the driver access budget monitor.
// ----------------------------------------------------------------------------
package dabm_pkg;

	localparam logic OP_ACTIVATE = 1'b0;
	localparam logic OP_ACCESS   = 1'b1;

	localparam logic [1:0] KIND_MMIO   = 2'd0;
	localparam logic [1:0] KIND_DMA    = 2'd1;
	localparam logic [1:0] KIND_IRQ    = 2'd2;
	localparam logic [1:0] KIND_POLICY = 2'd3;

	localparam logic [1:0] REG_DMA_LIMIT     = 2'd0;
	localparam logic [1:0] REG_VIOL_THRESH   = 2'd1;
	localparam logic [1:0] REG_DRIVER_COUNT  = 2'd2;

	localparam logic [47:0] DMA_LIMIT_RST    = 48'd268435456;
	localparam logic [15:0] VIOL_THRESH_RST  = 16'd16;
	localparam logic [8:0]  DRIVER_COUNT_RST = 9'd0;

	typedef struct packed {
		logic [31:0] mmio;
		logic [47:0] dma;
		logic [31:0] irq;
		logic [15:0] viol;
	} dabm_rec_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] violation_total;
		logic        revoke_request;
		logic        dma_over_limit;
		logic [47:0] dma_total;
		logic [31:0] mmio_total;
		logic [31:0] irq_total;
	} dabm_result_t;

	typedef struct packed {
		logic load;
		logic commit;
	} dabm_cmd_t;

endpackage

>>> hdl/driver_access_budget_monitor_top.sv
// ----------------------------------------------------------------------------
// driver_access_budget_monitor_top
// Per-driver access budget monitor: activity flags, saturating MMIO, DMA,
// IRQ and violation counters, revoke on policy threshold.
// Input beat and record are registered on load, the result on commit.
// No new item is taken until the last commits (record table read, then
// update and write-back); commit waits while out_stall holds a result.
// Reset: sequencer, result valid and activity flags cleared, configuration to
// defaults; record counters are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module driver_access_budget_monitor_top #(
	parameter int DRIVER_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  driver_index,
	input  logic [1:0]  access_kind,
	input  logic [31:0] transfer_length,
	input  logic [63:0] timestamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [15:0] violation_total,
	output logic        revoke_request,
	output logic        dma_over_limit,
	output logic [47:0] dma_total,
	output logic [31:0] mmio_total,
	output logic [31:0] irq_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);
	import dabm_pkg::*;

	dabm_cmd_t    cmd;
	dabm_result_t result;

	assign cfg_ready = 1'b1;

	dabm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dabm_datapath #(
		.DRIVER_SLOTS (DRIVER_SLOTS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.driver_index    (driver_index),
		.access_kind     (access_kind),
		.transfer_length (transfer_length),
		.timestamp       (timestamp),
		.result          (result)
	);

	assign accepted        = result.accepted;
	assign violation_total = result.violation_total;
	assign revoke_request  = result.revoke_request;
	assign dma_over_limit  = result.dma_over_limit;
	assign dma_total       = result.dma_total;
	assign mmio_total      = result.mmio_total;
	assign irq_total       = result.irq_total;

endmodule

>>> hdl/dabm_ctrl.sv
// ----------------------------------------------------------------------------
// dabm_ctrl
// Sequencer: takes an input beat, runs the record update and owns the
// output beat valid.
// ----------------------------------------------------------------------------
module dabm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output dabm_pkg::dabm_cmd_t cmd
);
	import dabm_pkg::*;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_UPDATE = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free  = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.commit = (state_q == ST_UPDATE) && slot_free;
	assign out_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_load_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_UPDATE)
		else $error("load did not enter update");

	a_commit_shows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) && out_valid_q && out_stall |=>
		(state_q == ST_UPDATE) && out_valid_q)
		else $error("pending result overrun");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.commit)
		else $error("load and commit in one cycle");

endmodule

>>> hdl/dabm_datapath.sv
// ----------------------------------------------------------------------------
// dabm_datapath
// Record table, configuration registers, counter update and result register.
// ----------------------------------------------------------------------------
module dabm_datapath #(
	parameter int DRIVER_SLOTS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dabm_pkg::dabm_cmd_t    cmd,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [47:0]            cfg_data,
	input  logic                   operation,
	input  logic [7:0]             driver_index,
	input  logic [1:0]             access_kind,
	input  logic [31:0]            transfer_length,
	input  logic [63:0]            timestamp,
	output dabm_pkg::dabm_result_t result
);
	import dabm_pkg::*;

	localparam int IDX_W = (DRIVER_SLOTS > 1) ? $clog2(DRIVER_SLOTS) : 1;

	dabm_rec_t   rec_mem [DRIVER_SLOTS];
	logic [63:0] time_mem [DRIVER_SLOTS];
	logic [DRIVER_SLOTS-1:0] active_q;

	logic [47:0] dma_limit_q;
	logic [15:0] viol_thresh_q;
	logic [8:0]  driver_count_q;

	logic        op_q;
	logic [7:0]  idx_q;
	logic [1:0]  kind_q;
	logic [31:0] len_q;
	logic [63:0] time_q;
	logic        range_q;
	logic        act_q;
	dabm_rec_t   rec_q;
	dabm_result_t result_q;

	logic         in_range;
	logic         hit;
	logic [48:0]  dma_sum;
	logic [47:0]  dma_sat;
	logic         over;
	logic [15:0]  viol_inc;
	dabm_rec_t    rec_nxt;
	logic [63:0]  time_nxt;
	logic         revoke;
	dabm_result_t res_nxt;

	assign in_range = ({1'b0, driver_index} < 9'(DRIVER_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_limit_q    <= DMA_LIMIT_RST;
			viol_thresh_q  <= VIOL_THRESH_RST;
			driver_count_q <= DRIVER_COUNT_RST;
			active_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DMA_LIMIT:    dma_limit_q    <= cfg_data;
					REG_VIOL_THRESH:  viol_thresh_q  <= cfg_data[15:0];
					REG_DRIVER_COUNT: driver_count_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (cmd.commit && range_q && (op_q == OP_ACTIVATE))
				active_q[idx_q[IDX_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			idx_q   <= driver_index;
			kind_q  <= access_kind;
			len_q   <= transfer_length;
			time_q  <= timestamp;
			range_q <= in_range;
			act_q   <= in_range ? active_q[driver_index[IDX_W-1:0]] : 1'b0;
			rec_q   <= rec_mem[driver_index[IDX_W-1:0]];
		end
		if (cmd.commit && hit) begin
			rec_mem[idx_q[IDX_W-1:0]]  <= rec_nxt;
			time_mem[idx_q[IDX_W-1:0]] <= time_nxt;
		end
		if (cmd.commit)
			result_q <= res_nxt;
	end

	assign hit      = range_q && ((op_q == OP_ACTIVATE) || act_q);
	assign dma_sum  = {1'b0, rec_q.dma} + {17'd0, len_q};
	assign dma_sat  = dma_sum[48] ? {48{1'b1}} : dma_sum[47:0];
	assign over     = (kind_q == KIND_DMA) && (dma_sat > dma_limit_q);
	assign viol_inc = (rec_q.viol == 16'hFFFF) ? rec_q.viol : rec_q.viol + 16'd1;
	assign time_nxt = (op_q == OP_ACTIVATE) ? 64'd0 : time_q;

	always_comb begin
		rec_nxt = rec_q;
		case (kind_q)
			KIND_MMIO: begin
				if (rec_q.mmio != 32'hFFFF_FFFF)
					rec_nxt.mmio = rec_q.mmio + 32'd1;
			end
			KIND_DMA: begin
				rec_nxt.dma = dma_sat;
				if (over)
					rec_nxt.viol = viol_inc;
			end
			KIND_IRQ: begin
				if (rec_q.irq != 32'hFFFF_FFFF)
					rec_nxt.irq = rec_q.irq + 32'd1;
			end
			KIND_POLICY: rec_nxt.viol = viol_inc;
			default: ;
		endcase
		if (op_q == OP_ACTIVATE)
			rec_nxt = '0;
	end

	assign revoke = (kind_q == KIND_POLICY) && (rec_nxt.viol >= viol_thresh_q) &&
		({1'b0, idx_q} < driver_count_q);

	always_comb begin
		res_nxt = '0;
		if (hit) begin
			res_nxt.accepted = 1'b1;
			if (op_q == OP_ACCESS) begin
				res_nxt.violation_total = rec_nxt.viol;
				res_nxt.revoke_request  = revoke;
				res_nxt.dma_over_limit  = over;
				res_nxt.dma_total       = rec_nxt.dma;
				res_nxt.mmio_total      = rec_nxt.mmio;
				res_nxt.irq_total       = rec_nxt.irq;
			end
		end
	end

	assign result = result_q;

endmodule

>>> sim/tb_driver_access_budget_monitor_top.sv
// ----------------------------------------------------------------------------
// tb_driver_access_budget_monitor_top
// Self-checking bench for the driver access budget monitor. A clocked driver
// feeds access and activate beats from a pending queue, a shadow record table
// predicts each result, and a clocked monitor compares every result beat with
// the oldest prediction. Six register settings run back to back, with random
// source gaps and result stalls in three pacing modes.
// ----------------------------------------------------------------------------
module tb_driver_access_budget_monitor_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dabm_pkg::*;

	localparam int         SLOTS         = 16;
	localparam int         PHASES        = 6;
	localparam int         RANDOM_BEATS  = 200;
	localparam int         STALL_LIMIT   = 4000;
	localparam int         REPORT_LIMIT  = 10;
	localparam logic [1:0] REG_UNUSED    = 2'd3;

	typedef enum int {STALL_HEAVY, SOURCE_SPARSE, FULL_RATE} pacing_t;

	typedef struct packed {
		logic        operation;
		logic [7:0]  driver_index;
		logic [1:0]  access_kind;
		logic [31:0] transfer_length;
		logic [63:0] timestamp;
	} access_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = 1'b0;
	logic [7:0]  driver_index = '0;
	logic [1:0]  access_kind = '0;
	logic [31:0] transfer_length = '0;
	logic [63:0] timestamp = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        accepted;
	logic [15:0] violation_total;
	logic        revoke_request;
	logic        dma_over_limit;
	logic [47:0] dma_total;
	logic [31:0] mmio_total;
	logic [31:0] irq_total;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;

	access_beat_t pending_beats[$];
	dabm_result_t expected_results[$];
	access_beat_t presented;
	pacing_t      pacing = STALL_HEAVY;

	logic [47:0]  dma_limit = DMA_LIMIT_RST;
	logic [15:0]  viol_thresh = VIOL_THRESH_RST;
	logic [8:0]   driver_count = DRIVER_COUNT_RST;
	logic         slot_active [SLOTS];
	dabm_rec_t    budget_tab [SLOTS];
	logic [63:0]  last_touch [SLOTS];

	int beats_in = 0;
	int results_checked = 0;
	int revokes_seen = 0;
	int overs_seen = 0;
	int reg_writes = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	driver_access_budget_monitor_top #(
		.DRIVER_SLOTS(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.driver_index(driver_index),
		.access_kind(access_kind),
		.transfer_length(transfer_length),
		.timestamp(timestamp),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.violation_total(violation_total),
		.revoke_request(revoke_request),
		.dma_over_limit(dma_over_limit),
		.dma_total(dma_total),
		.mmio_total(mmio_total),
		.irq_total(irq_total),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_active[i] = 1'b0;
			budget_tab[i]  = '0;
			last_touch[i]  = '0;
		end
	end

	function automatic dabm_result_t predict_budget_result(input access_beat_t b);
		dabm_result_t r;
		logic [48:0]  sum;
		int           i;
		r = '0;
		i = b.driver_index;
		if (i >= SLOTS)
			return r;
		if (b.operation == OP_ACTIVATE) begin
			slot_active[i] = 1'b1;
			budget_tab[i]  = '0;
			last_touch[i]  = '0;
			r.accepted     = 1'b1;
			return r;
		end
		if (!slot_active[i])
			return r;
		last_touch[i] = b.timestamp;
		case (b.access_kind)
			KIND_MMIO: begin
				if (budget_tab[i].mmio != '1)
					budget_tab[i].mmio = budget_tab[i].mmio + 32'd1;
			end
			KIND_DMA: begin
				sum = {1'b0, budget_tab[i].dma} + {17'd0, b.transfer_length};
				budget_tab[i].dma = sum[48] ? '1 : sum[47:0];
				if (budget_tab[i].dma > dma_limit) begin
					r.dma_over_limit = 1'b1;
					if (budget_tab[i].viol != '1)
						budget_tab[i].viol = budget_tab[i].viol + 16'd1;
				end
			end
			KIND_IRQ: begin
				if (budget_tab[i].irq != '1)
					budget_tab[i].irq = budget_tab[i].irq + 32'd1;
			end
			default: begin
				if (budget_tab[i].viol != '1)
					budget_tab[i].viol = budget_tab[i].viol + 16'd1;
				if (budget_tab[i].viol >= viol_thresh && {1'b0, b.driver_index} < driver_count)
					r.revoke_request = 1'b1;
			end
		endcase
		r.accepted        = 1'b1;
		r.violation_total = budget_tab[i].viol;
		r.dma_total       = budget_tab[i].dma;
		r.mmio_total      = budget_tab[i].mmio;
		r.irq_total       = budget_tab[i].irq;
		return r;
	endfunction

	function automatic bit roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic access_beat_t make_beat(input logic op, input logic [7:0] idx,
			input logic [1:0] kind, input logic [31:0] len, input logic [63:0] ts);
		access_beat_t b;
		b.operation       = op;
		b.driver_index    = idx;
		b.access_kind     = kind;
		b.transfer_length = len;
		b.timestamp       = ts;
		return b;
	endfunction

	function automatic access_beat_t random_beat();
		access_beat_t b;
		int           pick;
		b.operation    = roll(6) ? OP_ACTIVATE : OP_ACCESS;
		b.driver_index = roll(85) ? 8'($urandom_range(0, SLOTS - 1)) : 8'($urandom_range(0, 255));
		b.access_kind  = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 40)
			b.transfer_length = $urandom_range(0, 4096);
		else if (pick < 70)
			b.transfer_length = $urandom;
		else if (pick < 85)
			b.transfer_length = '1;
		else
			b.transfer_length = '0;
		b.timestamp = {$urandom, $urandom};
		return b;
	endfunction

	// source side: hold a stalled beat, advance on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_budget_result(presented));
				beats_in++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_beats.size() != 0 &&
						!roll(pacing == STALL_HEAVY ? 9 : pacing == SOURCE_SPARSE ? 85 : 0)) begin
					presented       = pending_beats.pop_front();
					in_valid        <= 1'b1;
					operation       <= presented.operation;
					driver_index    <= presented.driver_index;
					access_kind     <= presented.access_kind;
					transfer_length <= presented.transfer_length;
					timestamp       <= presented.timestamp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side: check each beat against the oldest prediction
	always @(posedge clk) begin
		dabm_result_t got;
		dabm_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{accepted, violation_total, revoke_request, dma_over_limit,
					dma_total, mmio_total, irq_total};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected result beat: acc=%0d viol=%0d rev=%0d over=%0d",
							got.accepted, got.violation_total, got.revoke_request,
							got.dma_over_limit);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.revoke_request)
						revokes_seen++;
					if (want.dma_over_limit)
						overs_seen++;
					if (got.accepted !== want.accepted ||
							got.violation_total !== want.violation_total ||
							got.revoke_request !== want.revoke_request ||
							got.dma_over_limit !== want.dma_over_limit ||
							got.dma_total !== want.dma_total ||
							got.mmio_total !== want.mmio_total ||
							got.irq_total !== want.irq_total) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("mismatch on result %0d at %0t", results_checked, $realtime);
							$display("  exp acc=%0d viol=%0d rev=%0d over=%0d dma=%h mmio=%h irq=%h",
								want.accepted, want.violation_total, want.revoke_request,
								want.dma_over_limit, want.dma_total, want.mmio_total,
								want.irq_total);
							$display("  got acc=%0d viol=%0d rev=%0d over=%0d dma=%h mmio=%h irq=%h",
								got.accepted, got.violation_total, got.revoke_request,
								got.dma_over_limit, got.dma_total, got.mmio_total,
								got.irq_total);
						end
					end
				end
			end
			out_stall <= roll(pacing == STALL_HEAVY ? 85 : pacing == SOURCE_SPARSE ? 9 : 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DMA_LIMIT:    dma_limit = data;
			REG_VIOL_THRESH:  viol_thresh = data[15:0];
			REG_DRIVER_COUNT: driver_count = data[8:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic load_directed();
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd0,   KIND_MMIO,   32'd0, 64'd1));
		pending_beats.push_back(make_beat(OP_ACTIVATE, 8'd0,   KIND_MMIO,   32'd0, 64'd0));
		pending_beats.push_back(make_beat(OP_ACTIVATE, 8'd15,  KIND_POLICY, '1,    '1));
		pending_beats.push_back(make_beat(OP_ACTIVATE, 8'd16,  KIND_DMA,    32'd5, 64'd2));
		pending_beats.push_back(make_beat(OP_ACTIVATE, 8'd255, KIND_IRQ,    '1,    '1));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd255, KIND_POLICY, '1,    '1));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd0,   KIND_MMIO,   32'd0, 64'd0));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd0,   KIND_MMIO,   '1,    '1));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd0,   KIND_IRQ,    32'd7, 64'd3));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd0,   KIND_DMA,    32'd0, 64'd4));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd0,   KIND_DMA,    '1,    64'd5));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd15,  KIND_DMA,    32'd1, 64'd6));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd15,  KIND_POLICY, 32'd0, 64'd7));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd0,   KIND_POLICY, '1,    64'd8));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd7,   KIND_DMA,    '1,    64'd9));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd16,  KIND_MMIO,   32'd0, 64'd10));
		pending_beats.push_back(make_beat(OP_ACTIVATE, 8'd0,   KIND_DMA,    '1,    '1));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd0,   KIND_MMIO,   32'd0, 64'd11));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd15,  KIND_IRQ,    32'h5555_5555,
			64'h5555_5555_5555_5555));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd15,  KIND_DMA,    32'hAAAA_AAAA,
			64'hAAAA_AAAA_AAAA_AAAA));
		pending_beats.push_back(make_beat(OP_ACCESS,   8'd128, KIND_DMA,    32'd3, 64'd12));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			pacing = (p < 2) ? STALL_HEAVY : (p < 4) ? SOURCE_SPARSE : FULL_RATE;
			if (p != 0) begin
				@(posedge clk);
				case (p)
					1: begin
						write_reg(REG_DMA_LIMIT, 48'd0);
						write_reg(REG_VIOL_THRESH, 48'd1);
						write_reg(REG_DRIVER_COUNT, 48'd256);
					end
					2: begin
						write_reg(REG_DMA_LIMIT, '1);
						write_reg(REG_VIOL_THRESH, 48'd65535);
						write_reg(REG_DRIVER_COUNT, 48'd16);
						write_reg(REG_UNUSED, {$urandom, 16'($urandom)});
					end
					3: begin
						write_reg(REG_DMA_LIMIT, 48'($urandom_range(1, 1 << 24)));
						write_reg(REG_VIOL_THRESH, {$urandom, 16'h0000});
						write_reg(REG_DRIVER_COUNT, {$urandom, 7'h00, 9'h1FF});
					end
					4: begin
						write_reg(REG_DMA_LIMIT, 48'h0001_0000_0000);
						write_reg(REG_VIOL_THRESH, 48'($urandom_range(2, 20)));
						write_reg(REG_DRIVER_COUNT, 48'($urandom_range(1, SLOTS - 1)));
					end
					default: begin
						write_reg(REG_DMA_LIMIT, {16'($urandom), $urandom});
						write_reg(REG_VIOL_THRESH, 48'(VIOL_THRESH_RST));
						write_reg(REG_DRIVER_COUNT, 48'(DRIVER_COUNT_RST));
					end
				endcase
				cfg_valid <= 1'b0;
				@(negedge clk);
			end
			if (p == 0)
				load_directed();
			repeat (RANDOM_BEATS)
				pending_beats.push_back(random_beat());
		end
		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d beats in, %0d results checked, %0d revoke and %0d over-limit results",
			beats_in, results_checked, revokes_seen, overs_seen);
		$display("%0d register writes across %0d settings, %0d mismatches",
			reg_writes, PHASES, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
